FILE: rtl/itp_pkg.sv
package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int STK_CW      = $clog2(STACK_DEPTH + 1);

    localparam logic [STK_CW-1:0] STK_FULL = STK_CW'(STACK_DEPTH);

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_CARET  = 8'h5E;

    typedef logic [1:0] t_prec;

    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_LETTER,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_OP
    } t_cls;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       run_last;
        logic       expr_done;
        logic       error_flag;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic accept;
        logic load_in;
        logic push_in;
        logic push_item;
        logic pop_emit;
        logic drop_open;
        logic fin_item;
        logic fin_expr;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_valid;
        t_cls in_cls;
        logic in_last;
        t_cls item_cls;
        logic item_last;
        logic pop_ok;
        logic stack_empty;
        logic pend_v;
        logic emit_ok;
        logic out_free;
    } t_sts;

    function automatic t_prec prec_of(input logic [7:0] c);
        t_prec p;
        case (c)
            CH_PLUS, CH_MINUS: p = 2'd1;
            CH_STAR, CH_SLASH: p = 2'd2;
            CH_CARET:          p = 2'd3;
            default:           p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic t_cls classify(input logic [7:0] c);
        t_cls k;
        if (c == CH_SPACE) begin
            k = CLS_SPACE;
        end else if (c == CH_LPAREN) begin
            k = CLS_OPEN;
        end else if (c == CH_RPAREN) begin
            k = CLS_CLOSE;
        end else if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
            k = CLS_LETTER;
        end else begin
            k = CLS_OP;
        end
        return k;
    endfunction

endpackage

FILE: rtl/itp_if.sv
interface itp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       expr_end;

    modport source (output valid, output in_char, output expr_end, input ready);
    modport sink   (input valid, input in_char, input expr_end, output ready);
endinterface

interface itp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic       run_last;
    logic       expr_done;
    logic       error_flag;

    modport source (output valid, output out_char, output char_valid, output run_last,
                    output expr_done, output error_flag, input ready);
    modport sink   (input valid, input out_char, input char_valid, input run_last,
                    input expr_done, input error_flag, output ready);
endinterface

FILE: rtl/itp_ram.sv
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/itp_datapath.sv
module itp_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    itp_in_if.sink        i_in,
    itp_out_if.source     o_out,
    input  itp_pkg::t_cmd i_cmd,
    output itp_pkg::t_sts o_sts
);
    import itp_pkg::*;

    logic [7:0]        r_item_char, n_item_char;
    logic              r_item_last, n_item_last;
    t_cls              r_item_cls,  n_item_cls;
    logic [STK_CW-1:0] r_count,     n_count;
    logic [STK_CW-1:0] r_open,      n_open;
    logic [7:0]        r_top,       n_top;
    logic              r_top_ram,   n_top_ram;
    logic              r_err,       n_err;
    logic [7:0]        r_pend,      n_pend;
    logic              r_pend_v,    n_pend_v;
    logic              r_out_v,     n_out_v;
    t_out_item         r_out,       n_out;

    logic [7:0]        ram_rdata;
    logic [STK_CW-1:0] cnt_m2;
    logic [7:0]        top_char;
    logic [7:0]        push_char;
    logic              push_en;
    logic              stack_full;
    logic              ram_we;
    logic              out_free;

    // top lives in r_top after a push, in the RAM read port after a pop
    assign top_char   = r_top_ram ? ram_rdata : r_top;
    assign cnt_m2     = r_count - STK_CW'(2);
    assign stack_full = (r_count == STK_FULL);
    assign push_en    = i_cmd.push_in || i_cmd.push_item;
    assign push_char  = i_cmd.push_in ? i_in.in_char : r_item_char;
    assign ram_we     = push_en && !stack_full;
    assign out_free   = !r_out_v || o_out.ready;

    itp_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[STK_AW-1:0]),
        .i_wdata (push_char),
        .i_raddr (cnt_m2[STK_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_item_char = r_item_char;
        n_item_last = r_item_last;
        n_item_cls  = r_item_cls;
        n_count     = r_count;
        n_open      = r_open;
        n_top       = top_char;
        n_top_ram   = 1'b0;
        n_err       = r_err;
        n_pend      = r_pend;
        n_pend_v    = r_pend_v;
        n_out_v     = r_out_v && !o_out.ready;
        n_out       = r_out;

        if (i_cmd.accept) begin
            n_item_char = i_in.in_char;
            n_item_last = i_in.expr_end;
            n_item_cls  = classify(i_in.in_char);
            // an unmatched close is known up front, so every item it emits carries the flag
            if (classify(i_in.in_char) == CLS_CLOSE && r_open == '0) begin
                n_err = 1'b1;
            end
        end

        if (i_cmd.load_in) begin
            n_pend   = i_in.in_char;
            n_pend_v = 1'b1;
        end

        if (push_en) begin
            if (stack_full) begin
                n_err = 1'b1;
            end else begin
                n_count = r_count + STK_CW'(1);
                n_top   = push_char;
                if (push_char == CH_LPAREN) begin
                    n_open = r_open + STK_CW'(1);
                end
            end
        end

        if (i_cmd.pop_emit) begin
            n_count   = r_count - STK_CW'(1);
            n_top_ram = 1'b1;
            if (top_char == CH_LPAREN) begin
                n_open = r_open - STK_CW'(1);
            end
            n_pend   = top_char;
            n_pend_v = 1'b1;
            // release the held item, now known not to be the last one
            if (r_pend_v) begin
                n_out_v = 1'b1;
                n_out   = '{out_char: r_pend, char_valid: 1'b1, run_last: 1'b0,
                            expr_done: 1'b0, error_flag: r_err};
            end
        end

        if (i_cmd.drop_open) begin
            n_count   = r_count - STK_CW'(1);
            n_open    = r_open - STK_CW'(1);
            n_top_ram = 1'b1;
        end

        if (i_cmd.fin_item) begin
            n_out_v  = 1'b1;
            n_out    = '{out_char: r_pend, char_valid: 1'b1, run_last: 1'b1,
                         expr_done: 1'b0, error_flag: r_err};
            n_pend_v = 1'b0;
        end

        if (i_cmd.fin_expr) begin
            n_out_v   = 1'b1;
            n_out     = '{out_char: r_pend_v ? r_pend : 8'h00, char_valid: r_pend_v,
                          run_last: 1'b1, expr_done: 1'b1, error_flag: r_err};
            n_pend_v  = 1'b0;
            n_count   = '0;
            n_open    = '0;
            n_err     = 1'b0;
            n_top_ram = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_open    <= '0;
            r_top_ram <= 1'b0;
            r_err     <= 1'b0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_open    <= n_open;
            r_top_ram <= n_top_ram;
            r_err     <= n_err;
            r_pend_v  <= n_pend_v;
            r_out_v   <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item_char <= n_item_char;
        r_item_last <= n_item_last;
        r_item_cls  <= n_item_cls;
        r_top       <= n_top;
        r_pend      <= n_pend;
        r_out       <= n_out;
    end

    assign i_in.ready       = i_cmd.in_ready;
    assign o_out.valid      = r_out_v;
    assign o_out.out_char   = r_out.out_char;
    assign o_out.char_valid = r_out.char_valid;
    assign o_out.run_last   = r_out.run_last;
    assign o_out.expr_done  = r_out.expr_done;
    assign o_out.error_flag = r_out.error_flag;

    always_comb begin
        o_sts.in_valid    = i_in.valid;
        o_sts.in_cls      = classify(i_in.in_char);
        o_sts.in_last     = i_in.expr_end;
        o_sts.item_cls    = r_item_cls;
        o_sts.item_last   = r_item_last;
        o_sts.pop_ok      = (r_count != '0) && (top_char != CH_LPAREN) &&
                            ((r_item_cls == CLS_CLOSE) ||
                             (prec_of(r_item_char) <= prec_of(top_char)));
        o_sts.stack_empty = (r_count == '0);
        o_sts.pend_v      = r_pend_v;
        o_sts.emit_ok     = !r_pend_v || out_free;
        o_sts.out_free    = out_free;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= STK_FULL)
        else $error("stack count beyond depth");

    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= r_count)
        else $error("open-paren count exceeds stack count");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pop_emit || i_cmd.drop_open) |-> (r_count != '0))
        else $error("pop from empty stack");

    a_expr_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin_expr |=> (r_count == '0 && !r_err && !r_pend_v))
        else $error("expression state not cleared");

endmodule

FILE: rtl/itp_ctrl.sv
module itp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  itp_pkg::t_sts i_sts,
    output itp_pkg::t_cmd o_cmd
);
    import itp_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOOP  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;

        case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_sts.in_cls)
                        CLS_SPACE: begin
                            n_state = i_sts.in_last ? S_FLUSH : S_IDLE;
                        end
                        CLS_LETTER: begin
                            o_cmd.load_in = 1'b1;
                            n_state = i_sts.in_last ? S_FLUSH : S_FIN;
                        end
                        CLS_OPEN: begin
                            o_cmd.push_in = 1'b1;
                            n_state = i_sts.in_last ? S_FLUSH : S_IDLE;
                        end
                        default: begin
                            n_state = S_LOOP;
                        end
                    endcase
                end
            end

            S_LOOP: begin
                if (i_sts.pop_ok) begin
                    o_cmd.pop_emit = i_sts.emit_ok;
                end else begin
                    if (i_sts.item_cls == CLS_CLOSE) begin
                        o_cmd.drop_open = !i_sts.stack_empty;
                    end else begin
                        o_cmd.push_item = 1'b1;
                    end
                    if (i_sts.item_last) begin
                        n_state = S_FLUSH;
                    end else if (i_sts.pend_v) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_FLUSH: begin
                if (!i_sts.stack_empty) begin
                    o_cmd.pop_emit = i_sts.emit_ok;
                end else if (i_sts.out_free) begin
                    o_cmd.fin_expr = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin_item = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load_in, o_cmd.push_in, o_cmd.push_item, o_cmd.pop_emit,
                  o_cmd.drop_open, o_cmd.fin_item, o_cmd.fin_expr}))
        else $error("more than one datapath action in a cycle");

    a_fin_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> i_sts.pend_v)
        else $error("item finish without a held result");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state != S_IDLE) || !$past(i_sts.in_last))
        else $error("expression end accepted without flush");

endmodule

FILE: rtl/infix_to_postfix_converter_core.sv
// Infix-to-postfix converter (shunting-yard). Each input item carries one ASCII
// character and an end-of-expression flag; each result item carries one postfix
// character, with run_last on the final result of an input item, expr_done on the
// final result of an expression (an end-only marker with char_valid low if the
// expression end released nothing), and error_flag for an unmatched ')' or a push
// onto a full operator stack. A space or an '(' is handled as it is accepted; a
// letter is held, then released; an operator or ')' pops operators off the stack,
// then releases the last one it held, if any. An item that ends an expression
// instead pops every operator left on the stack and then closes the expression.
// The operator stack sits in a single-port-write RAM with a registered read, and
// the controller pops one entry per cycle while the output can take results.
// Output stalls hold the loop.
module infix_to_postfix_converter_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    itp_in_if.sink    i_in,
    itp_out_if.source o_out
);
    import itp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    itp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    itp_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule

FILE: sim/infix_to_postfix_converter_core_test.sv
module infix_to_postfix_converter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import itp_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } infix_item_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    itp_in_if  in_if();
    itp_out_if out_if();

    infix_to_postfix_converter_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // pending input characters and the postfix results they must release
    infix_item_t infix_q[$];
    t_out_item   postfix_q[$];

    // shadow operator stack
    logic [7:0]  op_stack [STACK_DEPTH];
    int unsigned op_depth = 0;
    logic        open_err = 1'b0;
    logic [7:0]  released[$];

    int unsigned pushed_cnt  = 0;
    int unsigned acc_cnt     = 0;
    int unsigned seen_cnt    = 0;
    int unsigned mismatches  = 0;
    int unsigned flagged_cnt = 0;
    int unsigned ends_cnt    = 0;
    int unsigned deepest     = 0;
    int unsigned stall_cnt   = 0;
    int unsigned src_gap     = 0;
    int unsigned snk_gap     = 0;
    logic        idle_on     = 1'b0;
    logic        sink_hold   = 1'b0;

    function automatic int unsigned op_rank(input logic [7:0] c);
        case (c)
            CH_PLUS, CH_MINUS: return 1;
            CH_STAR, CH_SLASH: return 2;
            CH_CARET:          return 3;
            default:           return 0;
        endcase
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic void push_op(input logic [7:0] c);
        if (op_depth < STACK_DEPTH) begin
            op_stack[op_depth] = c;
            op_depth++;
            if (op_depth > deepest) deepest = op_depth;
        end else begin
            open_err = 1'b1;
        end
    endfunction

    function automatic void pop_op();
        released.push_back(op_stack[op_depth - 1]);
        op_depth--;
    endfunction

    task automatic predict_postfix(input logic [7:0] c, input logic fin);
        t_out_item r;
        int unsigned k;
        released.delete();
        if (c == CH_LPAREN) begin
            push_op(c);
        end else if (c == CH_RPAREN) begin
            while (op_depth > 0 && op_stack[op_depth - 1] != CH_LPAREN) pop_op();
            if (op_depth > 0) op_depth--;
            else open_err = 1'b1;
        end else if (is_alpha(c)) begin
            released.push_back(c);
        end else if (c != CH_SPACE) begin
            while (op_depth > 0 && op_stack[op_depth - 1] != CH_LPAREN
                   && op_rank(c) <= op_rank(op_stack[op_depth - 1])) pop_op();
            push_op(c);
        end
        if (fin) begin
            while (op_depth > 0) pop_op();
        end
        for (k = 0; k < released.size(); k++) begin
            r.out_char   = released[k];
            r.char_valid = 1'b1;
            r.run_last   = (k + 1 == released.size());
            r.expr_done  = fin && (k + 1 == released.size());
            r.error_flag = open_err;
            postfix_q.push_back(r);
        end
        // an end that releases nothing still closes the expression
        if (fin && released.size() == 0) begin
            r.out_char   = 8'h00;
            r.char_valid = 1'b0;
            r.run_last   = 1'b1;
            r.expr_done  = 1'b1;
            r.error_flag = open_err;
            postfix_q.push_back(r);
        end
        if (fin) begin
            op_depth = 0;
            open_err = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 25) $display("mismatch at result %0d: %s", seen_cnt, what);
    endtask

    task automatic add_char(input logic [7:0] c, input logic fin);
        infix_q.push_back('{ch: c, fin: fin});
        pushed_cnt++;
    endtask

    task automatic add_text(input string s, input logic fin);
        int i;
        for (i = 0; i < s.len(); i++) add_char(s[i], fin && (i == s.len() - 1));
    endtask

    task automatic close_expr();
        infix_q[$].fin = 1'b1;
    endtask

    function automatic logic [7:0] any_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? "a" : "A";
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] any_operator();
        string ops;
        logic [7:0] c;
        ops = "+-*/^";
        if ($urandom_range(0, 7) != 0) return ops[$urandom_range(0, 4)];
        // any symbol other than a letter, space or parenthesis
        do begin
            c = 8'($urandom_range(0, 255));
        end while (is_alpha(c) || c == CH_SPACE || c == CH_LPAREN || c == CH_RPAREN);
        return c;
    endfunction

    task automatic add_expr(input int lvl);
        int terms;
        int t;
        terms = $urandom_range(1, 4);
        for (t = 0; t < terms; t++) begin
            if (t > 0) add_char(any_operator(), 1'b0);
            if (lvl > 0 && $urandom_range(0, 3) == 0) begin
                add_char(CH_LPAREN, 1'b0);
                add_expr(lvl - 1);
                add_char(CH_RPAREN, 1'b0);
            end else begin
                add_char(any_letter(), 1'b0);
            end
            if ($urandom_range(0, 5) == 0) add_char(CH_SPACE, 1'b0);
        end
    endtask

    task automatic add_nest(input int n);
        int i;
        int closes;
        for (i = 0; i < n; i++) begin
            add_char(CH_LPAREN, 1'b0);
            if ($urandom_range(0, 2) == 0) begin
                add_char(any_letter(), 1'b0);
                add_char(any_operator(), 1'b0);
            end
        end
        add_char(any_letter(), 1'b0);
        closes = $urandom_range(0, n);
        for (i = 0; i < closes; i++) add_char(CH_RPAREN, 1'b0);
        close_expr();
    endtask

    task automatic wait_drained();
        while (infix_q.size() != 0 || in_if.valid || postfix_q.size() != 0)
            @(negedge i_clk);
    endtask

    // sender
    always @(posedge i_clk) begin
        infix_item_t nxt;
        if (!i_rst_n) begin
            in_if.valid    <= 1'b0;
            in_if.in_char  <= 8'h00;
            in_if.expr_end <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                acc_cnt++;
                predict_postfix(in_if.in_char, in_if.expr_end);
            end
            if (in_if.valid && !in_if.ready) stall_cnt++;
            if (!in_if.valid || in_if.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    in_if.valid <= 1'b0;
                end else if (infix_q.size() == 0) begin
                    in_if.valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 9) == 0) begin
                    src_gap = $urandom_range(0, 10);
                    in_if.valid <= 1'b0;
                end else begin
                    nxt = infix_q.pop_front();
                    in_if.valid    <= 1'b1;
                    in_if.in_char  <= nxt.ch;
                    in_if.expr_end <= nxt.fin;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                seen_cnt++;
                if (out_if.error_flag === 1'b1) flagged_cnt++;
                if (out_if.expr_done === 1'b1) ends_cnt++;
                if (postfix_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, char %h", out_if.out_char));
                end else begin
                    want = postfix_q.pop_front();
                    if (out_if.out_char !== want.out_char)
                        report_mismatch($sformatf("out_char %h, want %h",
                                                  out_if.out_char, want.out_char));
                    if (out_if.char_valid !== want.char_valid)
                        report_mismatch($sformatf("char_valid %b, want %b",
                                                  out_if.char_valid, want.char_valid));
                    if (out_if.run_last !== want.run_last)
                        report_mismatch($sformatf("run_last %b, want %b",
                                                  out_if.run_last, want.run_last));
                    if (out_if.expr_done !== want.expr_done)
                        report_mismatch($sformatf("expr_done %b, want %b",
                                                  out_if.expr_done, want.expr_done));
                    if (out_if.error_flag !== want.error_flag)
                        report_mismatch($sformatf("error_flag %b, want %b",
                                                  out_if.error_flag, want.error_flag));
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                out_if.ready <= 1'b0;
            end else if (sink_hold) begin
                out_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
                snk_gap = $urandom_range(0, 10);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        in_if.valid    = 1'b0;
        in_if.in_char  = 8'h00;
        in_if.expr_end = 1'b0;
        out_if.ready   = 1'b0;
        i_rst_n        = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // long back-pressure so the block fills up and stalls its input
    initial begin
        while (acc_cnt < 60) @(negedge i_clk);
        sink_hold = 1'b1;
        repeat (150) @(negedge i_clk);
        sink_hold = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("timeout with %0d results outstanding", postfix_q.size());
        $display("[infix_to_postfix_converter_core] ERROR");
        $finish;
    end

    initial begin
        int pick;
        logic deep_done;
        deep_done = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);

        add_text("a+b*c", 1'b1);
        add_text("(A-Z)/x^z", 1'b1);
        add_text(" ", 1'b1);
        add_text("q)", 1'b1);
        add_char(8'h00, 1'b0);
        add_char(8'hFF, 1'b0);
        add_char("@", 1'b0);
        add_char(CH_LPAREN, 1'b0);
        add_char(CH_SPACE, 1'b0);
        add_char("{", 1'b1);
        wait_drained();

        idle_on = 1'b1;
        while (pushed_cnt < 170) begin
            while (infix_q.size() > 8) @(negedge i_clk);
            if (pushed_cnt >= 140) idle_on = 1'b0;
            pick = $urandom_range(0, 19);
            if (!deep_done && pushed_cnt >= 70) begin
                // overflow the operator stack
                add_nest($urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 4));
                deep_done = 1'b1;
            end else if (pick < 13) begin
                add_expr(2);
                close_expr();
            end else if (pick < 15) begin
                repeat ($urandom_range(1, 5)) add_char(8'($urandom_range(0, 255)), 1'b0);
                close_expr();
            end else if (pick < 18) begin
                if ($urandom_range(0, 1)) add_char(CH_LPAREN, 1'b0);
                add_expr(1);
                if ($urandom_range(0, 1)) add_char(CH_RPAREN, 1'b0);
                if ($urandom_range(0, 1)) add_char(any_letter(), 1'b0);
                close_expr();
            end else begin
                add_nest($urandom_range(2, 10));
            end
        end
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (postfix_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", postfix_q.size()));

        $display("covered %0d input characters, %0d postfix results, %0d expression ends",
                 acc_cnt, seen_cnt, ends_cnt);
        $display("%0d error-flagged results, stack depth up to %0d, input stalled %0d cycles",
                 flagged_cnt, deepest, stall_cnt);
        if (mismatches == 0) begin
            $display("[infix_to_postfix_converter_core] OK");
        end else begin
            $display("[infix_to_postfix_converter_core] ERROR");
        end
        $finish;
    end

endmodule
